[rtl/wcp_pkg.sv]
// ----------------------------------------------------------------------------
// wcp_pkg
// shared types and constants of the wake-word confidence penalty block
// ----------------------------------------------------------------------------
package wcp_pkg;

    // default number of keyword stamp entries
    localparam int unsigned NUM_WORDS_DEF = 8;

    // field widths
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CONF_W  = 32;
    localparam int unsigned FRAME_W = 31;
    localparam int unsigned DUR_W   = 16;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 2;

    // configuration port
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // register reset values
    localparam logic [DUR_W-1:0] QUIET_RST = 16'd100;

    // register indexes
    typedef enum logic [2:0] {
        REG_ALL_DUR    = 3'd0,
        REG_SPEECH_DUR = 3'd1,
        REG_REDUCE_OFF = 3'd2,
        REG_EASY_WIN   = 3'd3,
        REG_EASY_OFF   = 3'd4,
        REG_MARGIN     = 3'd5,
        REG_QUIET      = 3'd6,
        REG_RESTART_EN = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DUR_W-1:0]         all_dur;
        logic [DUR_W-1:0]         speech_dur;
        logic signed [CONF_W-1:0] reduce_off;
        logic [DUR_W-1:0]         easy_win;
        logic signed [CONF_W-1:0] easy_off;
        logic signed [CONF_W-1:0] margin;
        logic [DUR_W-1:0]         quiet;
        logic                     restart_en;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]         word_index;
        logic signed [CONF_W-1:0] confidence;
        logic signed [CONF_W-1:0] word_threshold;
        logic [FRAME_W-1:0]       frame_number;
        logic [FRAME_W-1:0]       all_frame_count;
        logic [FRAME_W-1:0]       speech_frame_count;
    } t_item;

    typedef struct packed {
        logic signed [CONF_W-1:0] adjusted_confidence;
        logic                     reduce_applied;
        logic                     easy_applied;
    } t_result;

    typedef struct packed {
        logic [FRAME_W-1:0] prev;
        logic [FRAME_W-1:0] cur;
    } t_stamps;

endpackage

[rtl/wakeword_confidence_penalty_top.sv]
// ----------------------------------------------------------------------------
// wakeword_confidence_penalty_top
// per-keyword confidence adjustment with false-reduce and easy-wakeup offsets
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side is not stalled
// and returns one result per item, after the input register and the result
// register. The per-keyword stamp table is read and written back between those
// registers, so back-to-back items for the same keyword see each other's stamp
// updates without stalls. Stalls on the result side hold the input register;
// the input side keeps taking items while the result register is empty or
// being drained. Stamps clear at reset; all configuration registers are at
// byte address 4*index on the APB-style port and should be written only
// while no item is in flight.
// ----------------------------------------------------------------------------
module wakeword_confidence_penalty_top #(
    parameter int unsigned NUM_WORDS = wcp_pkg::NUM_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // word_index[2:0], confidence[34:3], word_threshold[66:35],
    // frame_number[97:67], all_frame_count[128:98], speech_frame_count[159:129]
    input  logic [wcp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // adjusted_confidence[31:0]
    output logic [wcp_pkg::M_TDATA_W-1:0] o_m_tdata,
    // reduce_applied[0], easy_applied[1]
    output logic [wcp_pkg::M_TUSER_W-1:0] o_m_tuser,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcp_pkg::APB_AW-1:0]    paddr,
    input  logic [wcp_pkg::APB_DW-1:0]    pwdata,
    output logic [wcp_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    // only eight keywords are reachable through the 3-bit index
    localparam int unsigned TBL_DEPTH = (NUM_WORDS < 8) ? NUM_WORDS : 8;
    localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    wcp_pkg::t_cfg     r_cfg;
    wcp_pkg::t_reg_idx w_reg_idx;
    logic              w_cfg_wr;

    wcp_pkg::t_item    r_item;
    logic              r_item_vld;
    wcp_pkg::t_result  r_res;
    logic              r_res_vld;

    logic [30:0]       r_prev_tbl [TBL_DEPTH];
    logic [30:0]       r_cur_tbl  [TBL_DEPTH];

    logic              w_advance;
    logic              w_idx_ok;
    logic [TBL_AW-1:0] w_tbl_addr;
    wcp_pkg::t_stamps  w_rd_stamps;
    wcp_pkg::t_stamps  w_wr_stamps;
    wcp_pkg::t_result  w_res;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = wcp_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.all_dur    <= '0;
            r_cfg.speech_dur <= '0;
            r_cfg.reduce_off <= '0;
            r_cfg.easy_win   <= '0;
            r_cfg.easy_off   <= '0;
            r_cfg.margin     <= '0;
            r_cfg.quiet      <= wcp_pkg::QUIET_RST;
            r_cfg.restart_en <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                wcp_pkg::REG_ALL_DUR:    r_cfg.all_dur    <= pwdata[15:0];
                wcp_pkg::REG_SPEECH_DUR: r_cfg.speech_dur <= pwdata[15:0];
                wcp_pkg::REG_REDUCE_OFF: r_cfg.reduce_off <= pwdata;
                wcp_pkg::REG_EASY_WIN:   r_cfg.easy_win   <= pwdata[15:0];
                wcp_pkg::REG_EASY_OFF:   r_cfg.easy_off   <= pwdata;
                wcp_pkg::REG_MARGIN:     r_cfg.margin     <= pwdata;
                wcp_pkg::REG_QUIET:      r_cfg.quiet      <= pwdata[15:0];
                wcp_pkg::REG_RESTART_EN: r_cfg.restart_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            wcp_pkg::REG_ALL_DUR:    prdata = {16'd0, r_cfg.all_dur};
            wcp_pkg::REG_SPEECH_DUR: prdata = {16'd0, r_cfg.speech_dur};
            wcp_pkg::REG_REDUCE_OFF: prdata = r_cfg.reduce_off;
            wcp_pkg::REG_EASY_WIN:   prdata = {16'd0, r_cfg.easy_win};
            wcp_pkg::REG_EASY_OFF:   prdata = r_cfg.easy_off;
            wcp_pkg::REG_MARGIN:     prdata = r_cfg.margin;
            wcp_pkg::REG_QUIET:      prdata = {16'd0, r_cfg.quiet};
            wcp_pkg::REG_RESTART_EN: prdata = {31'd0, r_cfg.restart_en};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- item flow ----------------
    // the input register moves on when the result register is free or drains
    assign w_advance  = !r_res_vld || i_m_tready;
    assign o_s_tready = !r_item_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_item_vld <= i_s_tvalid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.word_index         <= i_s_tdata[2:0];
            r_item.confidence         <= i_s_tdata[34:3];
            r_item.word_threshold     <= i_s_tdata[66:35];
            r_item.frame_number       <= i_s_tdata[97:67];
            r_item.all_frame_count    <= i_s_tdata[128:98];
            r_item.speech_frame_count <= i_s_tdata[159:129];
        end
    end

    // ---------------- stamp table ----------------
    // index past the configured word count reads zero and is never written
    assign w_idx_ok   = 32'(r_item.word_index) < NUM_WORDS;
    assign w_tbl_addr = TBL_AW'(r_item.word_index);

    always_comb begin
        if (w_idx_ok) begin
            w_rd_stamps.prev = r_prev_tbl[w_tbl_addr];
            w_rd_stamps.cur  = r_cur_tbl[w_tbl_addr];
        end else begin
            w_rd_stamps.prev = '0;
            w_rd_stamps.cur  = '0;
        end
    end

    wcp_calc u_calc (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_stamps (w_rd_stamps),
        .o_stamps (w_wr_stamps),
        .o_result (w_res)
    );

    // stamps are written back as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_prev_tbl[i] <= '0;
                r_cur_tbl[i]  <= '0;
            end
        end else if (r_item_vld && w_advance && w_idx_ok) begin
            r_prev_tbl[w_tbl_addr] <= w_wr_stamps.prev;
            r_cur_tbl[w_tbl_addr]  <= w_wr_stamps.cur;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_advance) begin
            r_res_vld <= r_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_item_vld) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_res_vld;
    assign o_m_tdata  = r_res.adjusted_confidence;
    assign o_m_tuser  = {r_res.easy_applied, r_res.reduce_applied};

endmodule

[rtl/wcp_calc.sv]
// ----------------------------------------------------------------------------
// wcp_calc
// offset decision, stamp update and saturation for one item
// ----------------------------------------------------------------------------
module wcp_calc (
    input  wcp_pkg::t_cfg    i_cfg,
    input  wcp_pkg::t_item   i_item,
    input  wcp_pkg::t_stamps i_stamps,
    output wcp_pkg::t_stamps o_stamps,
    output wcp_pkg::t_result o_result
);

    logic signed [31:0] win_s;
    logic signed [31:0] quiet_s;
    logic signed [31:0] diff_prev;
    logic signed [31:0] diff_new;
    logic signed [31:0] diff_cur;
    logic               age_out;
    logic [30:0]        prev_n;
    logic [30:0]        cur_mid;
    logic               easy_gap;
    logic               restart;
    logic               red;
    logic               easy;
    logic signed [33:0] sum;
    logic signed [34:0] near_sum;
    logic               near;

    always_comb begin
        win_s   = $signed({16'd0, i_cfg.easy_win});
        quiet_s = $signed({16'd0, i_cfg.quiet});

        red = (i_item.all_frame_count > {15'd0, i_cfg.all_dur})
            && (i_item.speech_frame_count > {15'd0, i_cfg.speech_dur});

        // drop a stale previous stamp, shift the current one down
        diff_prev = $signed({1'b0, i_item.frame_number}) - $signed({1'b0, i_stamps.prev});
        age_out   = (i_stamps.prev == '0) || (diff_prev > win_s);
        prev_n    = age_out ? i_stamps.cur : i_stamps.prev;
        cur_mid   = age_out ? '0 : i_stamps.cur;

        diff_new = $signed({1'b0, i_item.frame_number}) - $signed({1'b0, prev_n});
        easy_gap = diff_new > quiet_s;
        easy     = age_out ? ((prev_n != '0) && easy_gap) : easy_gap;

        restart = i_cfg.restart_en && (i_item.frame_number <= {15'd0, i_cfg.easy_win});
        if (restart) begin
            easy = 1'b1;
        end

        sum = 34'(i_item.confidence)
            + (red  ? 34'(i_cfg.reduce_off) : 34'sd0)
            + (easy ? 34'(i_cfg.easy_off)   : 34'sd0);

        near_sum = 35'(sum) + 35'(i_cfg.margin);
        near     = near_sum > 35'(i_item.word_threshold);

        diff_cur = $signed({1'b0, i_item.frame_number}) - $signed({1'b0, cur_mid});

        o_stamps.prev = prev_n;
        if (near) begin
            o_stamps.cur = i_item.frame_number;
        end else if (diff_cur > win_s) begin
            o_stamps.cur = '0;
        end else begin
            o_stamps.cur = cur_mid;
        end

        // saturate to 32 bits signed
        if (sum > 34'sh0_7FFF_FFFF) begin
            o_result.adjusted_confidence = 32'sh7FFF_FFFF;
        end else if (sum < -34'sh0_8000_0000) begin
            o_result.adjusted_confidence = 32'sh8000_0000;
        end else begin
            o_result.adjusted_confidence = sum[31:0];
        end
        o_result.reduce_applied = red;
        o_result.easy_applied   = easy;
    end

endmodule
